/* design/dlfb_pkg.sv */
`default_nettype none

package dlfb_pkg;

  // Default frame geometry
  localparam int DISPLAY_WIDTH_DEF = 128;
  localparam int DISPLAY_PAGES_DEF = 4;

  // Label layout
  localparam int DIGIT_COUNT = 5;
  localparam int FONT_COLS   = 5;
  localparam int ZOOM        = 2;
  localparam int GAP         = 2;
  localparam int CELL        = FONT_COLS * ZOOM + GAP;
  localparam int LABEL_SPAN  = DIGIT_COUNT * FONT_COLS * ZOOM + (DIGIT_COUNT - 1) * GAP;

  localparam logic [15:0] ANGLE_MAX = 16'd16383;
  localparam logic [3:0]  GLYPH_DASH = 4'd10;

  // Division by a place value: q = (angle * recip) >> RECIP_SHIFT
  localparam int RECIP_SHIFT = 27;
  // Division by ten of the quotient: q10 = (q * TEN_RECIP) >> TEN_SHIFT
  localparam logic [16:0] TEN_RECIP = 17'd52429;
  localparam int TEN_SHIFT = 19;

  typedef struct packed {
    logic       hit;    // pixel column lies on a glyph column
    logic       dash;   // show dashes instead of digits
    logic [2:0] fcol;   // font column 0..4
    logic [1:0] page;
  } dlfb_tag_t;

  // Reciprocal of the place value for digit position 0 (ten thousands) .. 4 (units)
  function automatic logic [27:0] place_recip(input logic [2:0] pos);
    logic [27:0] r;
    unique case (pos)
      3'd0:    r = 28'd13422;
      3'd1:    r = 28'd134218;
      3'd2:    r = 28'd1342178;
      3'd3:    r = 28'd13421773;
      3'd4:    r = 28'd134217728;
      default: r = 28'd0;
    endcase
    return r;
  endfunction

  // One column of the 5x7 font, bit 0 is the top font row
  function automatic logic [7:0] font_column(input logic [3:0] glyph, input logic [2:0] col);
    logic [39:0] cols;
    logic [7:0]  c;
    unique case (glyph)
      4'd0:    cols = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
      4'd1:    cols = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
      4'd2:    cols = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
      4'd3:    cols = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
      4'd4:    cols = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
      4'd5:    cols = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
      4'd6:    cols = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
      4'd7:    cols = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
      4'd8:    cols = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      4'd9:    cols = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
      4'd10:   cols = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      default: cols = 40'd0;
    endcase
    unique case (col)
      3'd0:    c = cols[7:0];
      3'd1:    c = cols[15:8];
      3'd2:    c = cols[23:16];
      3'd3:    c = cols[31:24];
      3'd4:    c = cols[39:32];
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/dlfb_locate.sv */
`default_nettype none

module dlfb_locate #(
  parameter int DISPLAY_WIDTH = dlfb_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_PAGES = dlfb_pkg::DISPLAY_PAGES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [15:0]        angle,
  input  wire logic               reading_ok,
  input  wire logic [1:0]         page,
  input  wire logic [6:0]         column,
  output      logic               valid,
  output      logic [13:0]        quot,
  output      dlfb_pkg::dlfb_tag_t tag
);
  import dlfb_pkg::*;

  localparam logic [8:0] WIDTH_W = 9'(DISPLAY_WIDTH);
  localparam logic [3:0] PAGES_W = 4'(DISPLAY_PAGES);
  localparam logic [8:0] LEFT    = 9'((DISPLAY_WIDTH - LABEL_SPAN) / 2);
  localparam logic [8:0] RIGHT   = 9'((DISPLAY_WIDTH - LABEL_SPAN) / 2 + LABEL_SPAN);
  localparam logic [5:0] CELL_W  = 6'(CELL);
  localparam logic [5:0] GLYPH_W = 6'(FONT_COLS * ZOOM);

  logic [8:0]  col9;
  logic        in_label;
  logic [5:0]  rel;
  logic [2:0]  pos;
  logic [5:0]  offset;
  logic [41:0] prod;
  dlfb_tag_t   tag_next;

  always_comb begin
    col9     = {2'b00, column};
    in_label = (col9 < WIDTH_W) && (col9 >= LEFT) && (col9 < RIGHT)
               && ({2'b00, page} < PAGES_W);
    rel      = 6'(col9 - LEFT);
    // split the label column into digit cell and offset within the cell
    priority if (rel >= 6'(4 * CELL)) begin
      pos = 3'd4;
    end else if (rel >= 6'(3 * CELL)) begin
      pos = 3'd3;
    end else if (rel >= 6'(2 * CELL)) begin
      pos = 3'd2;
    end else if (rel >= CELL_W) begin
      pos = 3'd1;
    end else begin
      pos = 3'd0;
    end
    offset = 6'(rel - 6'(pos * CELL_W));

    tag_next.hit  = in_label && (offset < GLYPH_W);
    tag_next.dash = !reading_ok || (angle > ANGLE_MAX);
    tag_next.fcol = offset[3:1];
    tag_next.page = page;

    prod = {28'd0, angle[13:0]} * {14'd0, place_recip(pos)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    quot <= prod[RECIP_SHIFT +: 14];
    tag  <= tag_next;
  end

endmodule

`default_nettype wire

/* design/dlfb_digit.sv */
`default_nettype none

module dlfb_digit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic [13:0]         quot,
  input  wire dlfb_pkg::dlfb_tag_t in_tag,
  output      logic                valid,
  output      logic [3:0]          quot_lo,
  output      logic [3:0]          tens_lo,
  output      dlfb_pkg::dlfb_tag_t tag
);
  import dlfb_pkg::*;

  logic [30:0] prod;

  // only the low nibbles matter for quot - 10 * (quot / 10)
  assign prod = {17'd0, quot} * {14'd0, TEN_RECIP};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    quot_lo <= quot[3:0];
    tens_lo <= prod[TEN_SHIFT +: 4];
    tag     <= in_tag;
  end

endmodule

`default_nettype wire

/* design/dlfb_glyph.sv */
`default_nettype none

module dlfb_glyph (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic [3:0]          quot_lo,
  input  wire logic [3:0]          tens_lo,
  input  wire dlfb_pkg::dlfb_tag_t in_tag,
  output      logic                done,
  output      logic [7:0]          frame_byte
);
  import dlfb_pkg::*;

  logic [3:0] digit;
  logic [3:0] glyph;
  logic [7:0] bits;
  logic [4:0] y;
  logic [3:0] row;
  logic [7:0] byte_next;

  always_comb begin
    digit = quot_lo - ({tens_lo[0], 3'b000} + {tens_lo[2:0], 1'b0});
    glyph = in_tag.dash ? GLYPH_DASH : digit;
    bits  = font_column(glyph, in_tag.fcol);
    y     = 5'd0;
    row   = 4'd0;
    byte_next = 8'd0;
    // each font row covers two pixel rows, starting one row down
    for (int b = 0; b < 8; b++) begin
      y   = {in_tag.page, 3'(b)};
      row = 4'((y - 5'd1) >> 1);
      byte_next[b] = in_tag.hit && (y != 5'd0) && (row < 4'd7) && bits[row[2:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    frame_byte <= byte_next;
  end

endmodule

`default_nettype wire

/* design/decimal_label_frame_byte_render.sv */
`default_nettype none

// Channel   Handshake       Payload                              Direction
// -------   -------------   ----------------------------------   ---------
// request   start / busy    angle, reading_ok, page, column      in
// result    done (strobe)   frame_byte                           out
//
// One item enters per cycle; every item gives exactly one result.
// The stages are the input register, column decode with place-value
// divide multiplier, divide-by-ten multiplier, font lookup and row render.
// rst is synchronous; busy follows rst, so nothing is taken during reset,
// and reset drops every item in flight.
// The receiver cannot stall: done pulses for one cycle per result.

module decimal_label_frame_byte_render #(
  parameter int DISPLAY_WIDTH = dlfb_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_PAGES = dlfb_pkg::DISPLAY_PAGES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [15:0] angle,
  input  wire logic        reading_ok,
  input  wire logic [1:0]  page,
  input  wire logic [6:0]  column,
  output      logic        done,
  output      logic [7:0]  frame_byte
);
  import dlfb_pkg::*;

  // input register
  logic        in_valid;
  logic [15:0] in_angle;
  logic        in_ok;
  logic [1:0]  in_page;
  logic [6:0]  in_column;

  // stage outputs
  logic        loc_valid;
  logic [13:0] loc_quot;
  dlfb_tag_t   loc_tag;
  logic        dig_valid;
  logic [3:0]  dig_quot_lo;
  logic [3:0]  dig_tens_lo;
  dlfb_tag_t   dig_tag;

  // hold off requests only while reset is applied
  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
  end

  // capture the item; payload needs no reset
  always_ff @(posedge clk) begin
    in_angle  <= angle;
    in_ok     <= reading_ok;
    in_page   <= page;
    in_column <= column;
  end

  // decode the column and divide the angle by the digit's place value
  dlfb_locate #(
    .DISPLAY_WIDTH(DISPLAY_WIDTH),
    .DISPLAY_PAGES(DISPLAY_PAGES)
  ) u_locate (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .angle      (in_angle),
    .reading_ok (in_ok),
    .page       (in_page),
    .column     (in_column),
    .valid      (loc_valid),
    .quot       (loc_quot),
    .tag        (loc_tag)
  );

  // advance the quotient through the divide by ten
  dlfb_digit u_digit (
    .clk      (clk),
    .rst      (rst),
    .in_valid (loc_valid),
    .quot     (loc_quot),
    .in_tag   (loc_tag),
    .valid    (dig_valid),
    .quot_lo  (dig_quot_lo),
    .tens_lo  (dig_tens_lo),
    .tag      (dig_tag)
  );

  // form the digit, look up the font column and scale rows into the page
  dlfb_glyph u_glyph (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (dig_valid),
    .quot_lo    (dig_quot_lo),
    .tens_lo    (dig_tens_lo),
    .in_tag     (dig_tag),
    .done       (done),
    .frame_byte (frame_byte)
  );

  // every accepted item gives its result after the input register, locate, digit and glyph stages
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted item lost its result");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without an accepted item");

  // the label occupies pixel rows 1..14 only
  a_top_row: assert property (@(posedge clk) disable iff (rst)
    (done && $past(page, 4) == 2'd0) |-> !frame_byte[0])
    else $error("top pixel row drawn");

  a_low_pages: assert property (@(posedge clk) disable iff (rst)
    (done && $past(page[1], 4)) |-> (frame_byte == 8'd0))
    else $error("pixels below the label");

  // a dash lights only font row three, which is pixel rows 7 and 8
  a_dash_page0: assert property (@(posedge clk) disable iff (rst)
    (done && $past(!reading_ok && page == 2'd0, 4))
    |-> (frame_byte == 8'h00 || frame_byte == 8'h80))
    else $error("dash drawn at wrong rows");

endmodule

`default_nettype wire

/* test/decimal_label_frame_byte_render_tb.sv */
`default_nettype none

module decimal_label_frame_byte_render_tb;

  // Label geometry for the default 128 x 4-page frame
  localparam int LABEL_LEFT = (dlfb_pkg::DISPLAY_WIDTH_DEF - dlfb_pkg::LABEL_SPAN) / 2;
  localparam int LABEL_TOP  = 1;
  localparam int FONT_ROWS  = 7;
  localparam int GLYPH_W    = dlfb_pkg::FONT_COLS * dlfb_pkg::ZOOM;

  // 5x7 column font, digits 0..9 then the dash, five strips per glyph,
  // leftmost strip first, bit 0 is the top font row
  localparam logic [55*8-1:0] GLYPH_STRIPS = {
    8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E,
    8'h00, 8'h42, 8'h7F, 8'h40, 8'h00,
    8'h42, 8'h61, 8'h51, 8'h49, 8'h46,
    8'h21, 8'h41, 8'h45, 8'h4B, 8'h31,
    8'h18, 8'h14, 8'h12, 8'h7F, 8'h10,
    8'h27, 8'h45, 8'h45, 8'h45, 8'h39,
    8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30,
    8'h01, 8'h71, 8'h09, 8'h05, 8'h03,
    8'h36, 8'h49, 8'h49, 8'h49, 8'h36,
    8'h06, 8'h49, 8'h49, 8'h29, 8'h1E,
    8'h08, 8'h08, 8'h08, 8'h08, 8'h08
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] angle = '0;
  logic        reading_ok = 1'b0;
  logic [1:0]  page = '0;
  logic [6:0]  column = '0;
  logic        done;
  logic [7:0]  frame_byte;

  logic [7:0]  expected_bytes[$];
  int          items_taken = 0;
  int          directed_items = 0;
  int          bytes_checked = 0;
  int          mismatch_count = 0;

  decimal_label_frame_byte_render uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .angle      (angle),
    .reading_ok (reading_ok),
    .page       (page),
    .column     (column),
    .done       (done),
    .frame_byte (frame_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or never answers
  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

  // Work out the frame byte that one item should produce.
  function automatic logic [7:0] render_byte(input logic [15:0] a, input logic ok,
                                             input logic [1:0] pg, input logic [6:0] col);
    int          rel;
    int          digit_pos;
    int          sub;
    int          glyph;
    int          value;
    int          y;
    int          row;
    int          strip_idx;
    logic [7:0]  strip;
    logic [7:0]  pixels;
    pixels = '0;
    // Blank outside the frame and outside the label span
    if (pg >= dlfb_pkg::DISPLAY_PAGES_DEF || col >= dlfb_pkg::DISPLAY_WIDTH_DEF)
      return pixels;
    if (col < LABEL_LEFT || col >= LABEL_LEFT + dlfb_pkg::LABEL_SPAN)
      return pixels;
    rel       = col - LABEL_LEFT;
    digit_pos = rel / dlfb_pkg::CELL;
    sub       = rel % dlfb_pkg::CELL;
    // The two gap columns after each glyph stay dark
    if (sub >= GLYPH_W)
      return pixels;
    if (!ok || a > dlfb_pkg::ANGLE_MAX) begin
      glyph = dlfb_pkg::GLYPH_DASH;
    end else begin
      // Position 0 is the ten-thousands digit: strip one decimal place per step
      value = a;
      for (int i = digit_pos; i < dlfb_pkg::DIGIT_COUNT - 1; i++)
        value = value / 10;
      glyph = value % 10;
    end
    strip_idx = glyph * dlfb_pkg::FONT_COLS + sub / dlfb_pkg::ZOOM;
    strip     = GLYPH_STRIPS[(54 - strip_idx) * 8 +: 8];
    // Each font row covers two pixel rows, starting one row below the top
    for (int b = 0; b < 8; b++) begin
      y = pg * 8 + b;
      if (y >= LABEL_TOP) begin
        row = (y - LABEL_TOP) / dlfb_pkg::ZOOM;
        if (row < FONT_ROWS && strip[row])
          pixels[b] = 1'b1;
      end
    end
    return pixels;
  endfunction

  // Watch both sides of the block on every edge: queue the prediction for
  // each item taken, and compare each strobed byte with the oldest one.
  always @(posedge clk) begin
    if (start && !busy) begin
      expected_bytes.push_back(render_byte(angle, reading_ok, page, column));
      items_taken <= items_taken + 1;
    end
    if (done === 1'b1) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual frame_byte %02h",
                 $time, frame_byte);
        mismatch_count <= mismatch_count + 1;
      end else begin
        if (frame_byte !== expected_bytes[0]) begin
          $display("%0t: frame_byte mismatch, expected %02h, actual %02h",
                   $time, expected_bytes[0], frame_byte);
          mismatch_count <= mismatch_count + 1;
        end
        void'(expected_bytes.pop_front());
        bytes_checked <= bytes_checked + 1;
      end
    end
  end

  // Present one item, hold it until the block takes it, then idle the
  // request line for a few cycles with the given chance in a hundred.
  task automatic send_item(input logic [15:0] a, input logic ok,
                           input logic [1:0] pg, input logic [6:0] col,
                           input int idle_pct);
    start      <= 1'b1;
    angle      <= a;
    reading_ok <= ok;
    page       <= pg;
    column     <= col;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Column of the given strip inside digit position pos
  function automatic logic [6:0] digit_col(input int pos, input int strip);
    return 7'(LABEL_LEFT + pos * dlfb_pkg::CELL + strip);
  endfunction

  // Digit values in every position, on both lit pages; edges of the
  // valid angle range
  task automatic test_digit_extremes();
    send_item(16'd0,     1'b1, 2'd0, digit_col(0, 0), 0);
    send_item(16'd0,     1'b1, 2'd1, digit_col(4, 9), 0);
    send_item(16'd16383, 1'b1, 2'd0, digit_col(0, 2), 0);
    send_item(16'd16383, 1'b1, 2'd1, digit_col(1, 5), 0);
    send_item(16'd16383, 1'b1, 2'd0, digit_col(2, 7), 0);
    send_item(16'd16383, 1'b1, 2'd1, digit_col(3, 3), 0);
    send_item(16'd16383, 1'b1, 2'd0, digit_col(4, 4), 0);
    send_item(16'd12345, 1'b1, 2'd0, digit_col(3, 1), 0);
    send_item(16'd6789,  1'b1, 2'd1, digit_col(1, 6), 0);
    send_item(16'd6789,  1'b1, 2'd0, digit_col(4, 8), 0);
    directed_items += 10;
  endtask

  // Invalid reading flag and angles just past and far past the limit
  task automatic test_dash_cases();
    send_item(16'd5000,  1'b0, 2'd0, digit_col(0, 4), 0);
    send_item(16'd16384, 1'b1, 2'd0, digit_col(2, 0), 0);
    send_item(16'd16384, 1'b1, 2'd1, digit_col(2, 1), 0);
    send_item(16'hFFFF,  1'b1, 2'd0, digit_col(4, 9), 0);
    send_item(16'hFFFF,  1'b0, 2'd1, digit_col(3, 5), 0);
    directed_items += 5;
  endtask

  // Gap columns, columns on each side of the label, unlit pages
  task automatic test_blank_regions();
    send_item(16'd8888, 1'b1, 2'd0, 7'd0, 0);
    send_item(16'd8888, 1'b1, 2'd0, 7'(LABEL_LEFT - 1), 0);
    send_item(16'd8888, 1'b1, 2'd0, digit_col(0, GLYPH_W), 0);
    send_item(16'd8888, 1'b1, 2'd1, digit_col(3, GLYPH_W + 1), 0);
    send_item(16'd8888, 1'b1, 2'd0, 7'(LABEL_LEFT + dlfb_pkg::LABEL_SPAN), 0);
    send_item(16'd8888, 1'b1, 2'd0, 7'd127, 0);
    send_item(16'd8888, 1'b1, 2'd2, digit_col(1, 2), 0);
    send_item(16'd8888, 1'b1, 2'd3, digit_col(2, 3), 0);
    directed_items += 8;
  endtask

  // Random items, weighted toward the lit part of the frame and valid angles
  task automatic test_random_frames(input int count, input int idle_pct);
    logic [15:0] a;
    logic        ok;
    logic [1:0]  pg;
    logic [6:0]  col;
    int          pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(9);
      if (pick <= 5)
        a = 16'($urandom_range(16383));
      else if (pick == 6)
        case ($urandom_range(3))
          0:       a = 16'd0;
          1:       a = 16'd16383;
          2:       a = 16'd16384;
          default: a = 16'hFFFF;
        endcase
      else
        a = 16'($urandom());
      ok  = ($urandom_range(9) != 0);
      pg  = ($urandom_range(3) != 0) ? 2'($urandom_range(1)) : 2'($urandom_range(3));
      col = ($urandom_range(4) != 0) ?
            7'(LABEL_LEFT + $urandom_range(dlfb_pkg::LABEL_SPAN - 1)) :
            7'($urandom_range(127));
      send_item(a, ok, pg, col, idle_pct);
    end
  endtask

  initial begin
    int drain_cycles;
    // Hold reset, then release it once
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_digit_extremes();
    test_dash_cases();
    test_blank_regions();

    // Sender gaps: light, heavy, then back to back
    test_random_frames(630, 15);
    test_random_frames(630, 64);
    test_random_frames(630, 0);
    start <= 1'b0;

    // Drain whatever is still in the pipeline, then give it a few more edges
    drain_cycles = 0;
    while (expected_bytes.size() != 0 && drain_cycles < 200) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      $display("%0t: %0d frame bytes never arrived, expected %02h, actual none",
               $time, expected_bytes.size(), expected_bytes[0]);
      mismatch_count = mismatch_count + 1;
    end

    $display("Rendered %0d items (%0d directed) under three sender gap settings;",
             items_taken, directed_items);
    $display("compared %0d frame bytes, %0d mismatches.", bytes_checked, mismatch_count);
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
